// File: design/wildcard_byte_pattern_scanner_top_assert.svh
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_TOP_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WBPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define WBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/wbps_pkg.sv
package wbps_pkg;

  // Window and pattern geometry.
  localparam int MAX_PATTERN_BYTES = 16;
  localparam int REG_BYTES         = 16;
  localparam int NUM_CELLS         = MAX_PATTERN_BYTES;
  localparam int LEN_CAP_INT       = (MAX_PATTERN_BYTES < REG_BYTES) ? MAX_PATTERN_BYTES
                                                                     : REG_BYTES;
  localparam int LEN_W             = 5;
  localparam int PIDX_W            = 4;
  localparam int OFFSET_WIDTH      = 32;
  localparam int CNT_W             = 32;
  localparam int ADDR_W            = 64;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDR    = 3'd0,
    CFG_PATTERN_LOW  = 3'd1,
    CFG_PATTERN_HIGH = 3'd2,
    CFG_WILDCARD     = 3'd3,
    CFG_PATTERN_LEN  = 3'd4,
    CFG_FIRST_ONLY   = 3'd5
  } cfg_idx_t;

  // Control shared by every window cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // Pattern position that a cell compares against.
  typedef struct packed {
    logic       in_use;
    logic       wild;
    logic [7:0] pat_byte;
  } cell_pat_t;

  // One result item.
  typedef struct packed {
    logic [CNT_W-1:0]  match_total;
    logic              found_any;
    logic              end_of_scan;
    logic [ADDR_W-1:0] match_address;
  } result_t;

endpackage

// File: design/wbps_cell.sv
module wbps_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  wbps_pkg::cell_ctl_t ctl,
  input  wbps_pkg::cell_pat_t pat,
  input  logic [7:0]          byte_in,
  output logic [7:0]          byte_out,
  output logic                hit
);
  import wbps_pkg::*;

  logic [7:0] byte_r;

  // Window byte: takes byte_in on each transfer, cleared at scan end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else if (ctl.clear) begin
      byte_r <= 8'd0;
    end else if (ctl.shift) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  // The compare sees the byte that this cell takes in the current transfer.
  assign hit = !pat.in_use || pat.wild || (byte_in == pat.pat_byte);

endmodule

// File: design/wbps_out_fifo.sv
module wbps_out_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [1:0]                        push_cnt,
  input  wbps_pkg::result_t                 ent_a,
  input  wbps_pkg::result_t                 ent_b,
  input  logic                              pop,
  output wbps_pkg::result_t                 head,
  output logic                              head_valid,
  output logic [wbps_pkg::FIFO_CNT_W-1:0]   count
);
  import wbps_pkg::*;

  result_t                 slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;
  logic [FIFO_PTR_W-1:0]   wr_ptr_b;

  assign wr_ptr_b = wr_ptr_r + FIFO_PTR_W'(1);

  // Up to two entries go in per cycle, at consecutive slots.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      slot_r[wr_ptr_r] <= ent_a;
    end
    if (push_cnt == 2'd2) begin
      slot_r[wr_ptr_b] <= ent_b;
    end
  end

  // Pointer and fill level bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    count_nxt  = count_r + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign count      = count_r;

endmodule

// File: design/wildcard_byte_pattern_scanner_top.sv
// Results: the results of a byte are written into the result queue at its transfer and are
// presented on out_ from the queue head, behind any results still waiting there.
// Throughput: one byte per cycle, limited by the result queue draining one result per cycle;
// in_tready drops while the four-entry queue holds more than two results.
// Reset (rst_n low, synchronous): registers return to defaults (pattern_length 1, rest 0),
// the window and scan counters clear, and the result queue empties.
module wildcard_byte_pattern_scanner_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Input byte stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  logic                                in_tlast,   // last_byte
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [95:0]                         out_tdata,  // [63:0] match_address,
                                                          // [95:64] match_total
  output logic                                out_tuser,  // found_any
  output logic                                out_tlast   // end_of_scan
);
  import wbps_pkg::*;

  // Configuration registers.
  logic [ADDR_W-1:0] base_addr_r;
  logic [63:0]       pat_low_r;
  logic [63:0]       pat_high_r;
  logic [15:0]       wild_mask_r;
  logic [LEN_W-1:0]  pat_len_r;
  logic              first_only_r;

  // Scan state.
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic [CNT_W-1:0]  matches_r, matches_nxt;
  logic [ADDR_W-1:0] recorded_r, recorded_nxt;
  logic              stopped_r, stopped_nxt;

  logic                    accept;
  logic [LEN_W-1:0]        len_used;
  logic [REG_BYTES-1:0][7:0] pat_bytes;
  logic [7:0]              cell_byte [NUM_CELLS];
  logic [NUM_CELLS-1:0]    cell_hit;
  cell_ctl_t               cell_ctl;
  logic                    matched;
  logic [OFFSET_WIDTH-1:0] offset;
  logic [ADDR_W-1:0]       match_addr;
  logic [1:0]              push_cnt;
  result_t                 report, marker, ent_a, head;
  logic                    head_valid;
  logic [FIFO_CNT_W-1:0]   fifo_count;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_addr_r  <= '0;
      pat_low_r    <= '0;
      pat_high_r   <= '0;
      wild_mask_r  <= '0;
      pat_len_r    <= LEN_W'(1);
      first_only_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BASE_ADDR:    base_addr_r  <= cfg_wdata[ADDR_W-1:0];
        CFG_PATTERN_LOW:  pat_low_r    <= cfg_wdata[63:0];
        CFG_PATTERN_HIGH: pat_high_r   <= cfg_wdata[63:0];
        CFG_WILDCARD:     wild_mask_r  <= cfg_wdata[15:0];
        CFG_PATTERN_LEN:  pat_len_r    <= cfg_wdata[LEN_W-1:0];
        CFG_FIRST_ONLY:   first_only_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Length in use: zero acts as one, large values clip to the window size.
  always_comb begin
    if (pat_len_r == '0) begin
      len_used = LEN_W'(1);
    end else if (pat_len_r > LEN_W'(LEN_CAP_INT)) begin
      len_used = LEN_W'(LEN_CAP_INT);
    end else begin
      len_used = pat_len_r;
    end
  end

  assign pat_bytes = {pat_high_r, pat_low_r};

  assign cell_ctl.shift = accept;
  assign cell_ctl.clear = accept && in_tlast;

  // Shift window: cell 0 holds the newest byte, each cell compares against
  // pattern position len_used - 1 - i.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic [LEN_W-1:0] pidx;
    cell_pat_t        pat;
    logic [7:0]       byte_in;

    assign pidx         = len_used - LEN_W'(i) - LEN_W'(1);
    assign pat.in_use   = (LEN_W'(i) < len_used);
    assign pat.wild     = wild_mask_r[pidx[PIDX_W-1:0]];
    assign pat.pat_byte = pat_bytes[pidx[PIDX_W-1:0]];

    if (i == 0) begin : g_head
      assign byte_in = in_tdata;
    end else begin : g_link
      assign byte_in = cell_byte[i-1];
    end

    wbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .pat      (pat),
      .byte_in  (byte_in),
      .byte_out (cell_byte[i]),
      .hit      (cell_hit[i])
    );
  end

  // Match decision and scan state update for the byte in transfer.
  always_comb begin
    seen_nxt     = (seen_r == '1) ? seen_r : seen_r + CNT_W'(1);
    matched      = (seen_nxt >= CNT_W'(len_used)) && !stopped_r && (&cell_hit);
    offset       = OFFSET_WIDTH'(seen_nxt - CNT_W'(len_used));
    match_addr   = base_addr_r + ADDR_W'(offset);
    matches_nxt  = matches_r;
    recorded_nxt = recorded_r;
    stopped_nxt  = stopped_r;
    if (matched) begin
      if (matches_r != '1) begin
        matches_nxt = matches_r + CNT_W'(1);
      end
      recorded_nxt = match_addr;
      stopped_nxt  = first_only_r;
    end

    report.match_address = match_addr;
    report.end_of_scan   = 1'b0;
    report.found_any     = 1'b1;
    report.match_total   = matches_nxt;

    marker.end_of_scan   = 1'b1;
    marker.found_any     = (matches_nxt != '0);
    marker.match_address = (matches_nxt != '0) ? recorded_nxt : '0;
    marker.match_total   = matches_nxt;

    ent_a    = matched ? report : marker;
    push_cnt = accept ? (2'(matched) + 2'(in_tlast)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      matches_r  <= '0;
      recorded_r <= '0;
      stopped_r  <= 1'b0;
    end else if (accept) begin
      if (in_tlast) begin
        seen_r     <= '0;
        matches_r  <= '0;
        recorded_r <= '0;
        stopped_r  <= 1'b0;
      end else begin
        seen_r     <= seen_nxt;
        matches_r  <= matches_nxt;
        recorded_r <= recorded_nxt;
        stopped_r  <= stopped_nxt;
      end
    end
  end

  // Result queue between the compare and the output side.
  wbps_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .ent_a      (ent_a),
    .ent_b      (marker),
    .pop        (out_tvalid && out_tready),
    .head       (head),
    .head_valid (head_valid),
    .count      (fifo_count)
  );

  assign out_tvalid = head_valid;
  assign out_tdata  = {head.match_total, head.match_address};
  assign out_tuser  = head.found_any;
  assign out_tlast  = head.end_of_scan;

  // Checks on queue occupancy and scan bookkeeping.
  `include "wildcard_byte_pattern_scanner_top_assert.svh"

  `WBPS_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_count <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
  `WBPS_ASSERT_NOW(a_stop_has_match, stopped_r, matches_r != '0, "stopped without a match")
  `WBPS_ASSERT_NEXT(a_scan_cleared, accept && in_tlast, seen_r == '0 && matches_r == '0, "scan not cleared")

endmodule

// File: test/tb_wildcard_byte_pattern_scanner_top.sv
`timescale 1ns / 100ps

module tb_wildcard_byte_pattern_scanner_top;
  import wbps_pkg::*;

  localparam int WIN_BYTES    = MAX_PATTERN_BYTES;
  localparam int STREAM_BYTES = 1525;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  // One full set of register values.
  typedef struct {
    bit [63:0] base;
    bit [63:0] pat_lo;
    bit [63:0] pat_hi;
    bit [63:0] mask_word;
    bit [4:0]  plen;
    bit        first;
  } scan_setup_t;

  // Tracks the scan as the block should see it and holds the results still to come.
  class scan_tracker;
    bit [63:0] base_addr;
    bit [63:0] pat_lo;
    bit [63:0] pat_hi;
    bit [15:0] wild;
    bit [4:0]  plen;
    bit        first_only;
    bit [7:0]  win [WIN_BYTES];
    bit [31:0] seen;
    bit [31:0] found;
    bit [63:0] recorded;
    bit        stopped;
    result_t   expected_q [$];
    int        errors;
    int        bytes_in;
    int        reports;
    int        markers;

    function new();
      base_addr  = 64'h0;
      pat_lo     = 64'h0;
      pat_hi     = 64'h0;
      wild       = 16'h0;
      plen       = 5'd1;
      first_only = 1'b0;
      clear_scan();
    endfunction

    function void clear_scan();
      foreach (win[i]) win[i] = 8'h00;
      seen     = 32'h0;
      found    = 32'h0;
      recorded = 64'h0;
      stopped  = 1'b0;
    endfunction

    function void set_reg(cfg_idx_t idx, bit [63:0] v);
      case (idx)
        CFG_BASE_ADDR:    base_addr = v;
        CFG_PATTERN_LOW:  pat_lo = v;
        CFG_PATTERN_HIGH: pat_hi = v;
        CFG_WILDCARD:     wild = v[15:0];
        CFG_PATTERN_LEN:  plen = v[4:0];
        CFG_FIRST_ONLY:   first_only = v[0];
        default: ;
      endcase
    endfunction

    // Length zero acts as one, lengths past the register capacity are clipped.
    function int used_len();
      if (plen == 5'd0) return 1;
      if (plen > LEN_CAP_INT) return LEN_CAP_INT;
      return int'(plen);
    endfunction

    function bit [7:0] pat_byte(int k);
      bit [63:0] word;
      word = (k < 8) ? pat_lo : pat_hi;
      return word[(k % 8) * 8 +: 8];
    endfunction

    // Pattern byte 0 lines up with the oldest byte of the window.
    function bit window_hit(int len);
      for (int k = 0; k < len; k++)
        if (!wild[k] && win[len - 1 - k] != pat_byte(k)) return 1'b0;
      return 1'b1;
    endfunction

    function void note_byte(bit [7:0] d, bit l);
      int        len;
      bit [31:0] ofs;
      result_t   r;
      len = used_len();
      bytes_in++;
      for (int i = WIN_BYTES - 1; i > 0; i--) win[i] = win[i - 1];
      win[0] = d;
      if (seen != 32'hFFFF_FFFF) seen++;

      // Match report, suppressed once first-only mode has fired in this scan.
      if (seen >= len && !stopped && window_hit(len)) begin
        ofs      = seen - len;
        recorded = base_addr + {32'h0, ofs};
        if (found != 32'hFFFF_FFFF) found++;
        if (first_only) stopped = 1'b1;
        r.match_address = recorded;
        r.end_of_scan   = 1'b0;
        r.found_any     = 1'b1;
        r.match_total   = found;
        expected_q = {expected_q, r};
      end

      // End marker closes the image and restarts the scan.
      if (l) begin
        r.match_address = (found != 0) ? recorded : 64'h0;
        r.end_of_scan   = 1'b1;
        r.found_any     = (found != 0);
        r.match_total   = found;
        expected_q = {expected_q, r};
        clear_scan();
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result addr %h end %b found %b total %0d",
                 $time, got.match_address, got.end_of_scan, got.found_any, got.match_total);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t ns: expected addr %h end %b found %b total %0d", $time,
                 want.match_address, want.end_of_scan, want.found_any, want.match_total);
        $display("%0t ns: actual   addr %h end %b found %b total %0d", $time,
                 got.match_address, got.end_of_scan, got.found_any, got.match_total);
      end else if (want.end_of_scan) begin
        markers++;
      end else begin
        reports++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = 3'd0;
  logic [63:0] cfg_wdata  = 64'h0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  scan_tracker sb;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          setups = 0;

  wildcard_byte_pattern_scanner_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver side: random back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watch both channels; every input transfer feeds the tracker, every result is checked.
  always @(posedge clk) begin : monitor
    result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got.match_address = out_tdata[63:0];
        got.match_total   = out_tdata[95:64];
        got.found_any     = out_tuser;
        got.end_of_scan   = out_tlast;
        sb.check_result(got);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL wildcard_byte_pattern_scanner_top");
    $finish;
  end

  // Offer one byte, with random idle cycles first, and return after its transfer.
  task automatic send_byte(bit [7:0] d, bit l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every expected result is out and the block is quiet.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, bit [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_settings(scan_setup_t s);
    cfg_write(CFG_BASE_ADDR, s.base);
    cfg_write(CFG_PATTERN_LOW, s.pat_lo);
    cfg_write(CFG_PATTERN_HIGH, s.pat_hi);
    cfg_write(CFG_WILDCARD, s.mask_word);
    cfg_write(CFG_PATTERN_LEN, {59'h0, s.plen});
    cfg_write(CFG_FIRST_ONLY, {63'h0, s.first});
    cfg_we <= 1'b0;
    setups++;
  endtask

  function automatic scan_setup_t make_setup(bit [63:0] base, bit [63:0] lo, bit [63:0] hi,
                                             bit [63:0] mask_word, bit [4:0] plen, bit first);
    scan_setup_t s;
    s.base      = base;
    s.pat_lo    = lo;
    s.pat_hi    = hi;
    s.mask_word = mask_word;
    s.plen      = plen;
    s.first     = first;
    return s;
  endfunction

  function automatic bit [63:0] random_word();
    case ($urandom_range(3))
      0:       return 64'h0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Mostly short patterns so matches are frequent; now and then long or out-of-range lengths.
  function automatic scan_setup_t random_setup();
    scan_setup_t s;
    case ($urandom_range(3))
      0:       s.base = 64'h0;
      1:       s.base = '1;
      2:       s.base = {32'hFFFF_FFFF, $urandom()};
      default: s.base = {$urandom(), $urandom()};
    endcase
    s.pat_lo = random_word();
    s.pat_hi = random_word();
    case ($urandom_range(4))
      0:       s.mask_word = 64'h0;
      1:       s.mask_word = 64'hFFFF;
      2:       s.mask_word = {$urandom(), $urandom()};
      default: s.mask_word = {48'h0, 16'($urandom() & $urandom() & $urandom())};
    endcase
    case ($urandom_range(8))
      0, 1, 2, 3, 4: s.plen = 5'($urandom_range(1, 4));
      5, 6:          s.plen = 5'($urandom_range(5, 16));
      7:             s.plen = 5'd16;
      default:       s.plen = $urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31));
    endcase
    s.first = 1'($urandom_range(1));
    return s;
  endfunction

  // One image: mostly pattern-rich content with embedded copies; some pure noise,
  // some with a corrupted copy, and a few left open so the scan runs into the next phase.
  task automatic send_image();
    bit [7:0] img [$];
    int       len;
    int       n;
    int       kind;
    int       pos;
    bit       closed;
    len    = sb.used_len();
    n      = $urandom_range(1, len + 20);
    kind   = $urandom_range(9);
    closed = ($urandom_range(9) != 0);
    for (int i = 0; i < n; i++)
      img.push_back((kind == 0 || $urandom_range(1)) ? 8'($urandom_range(255))
                                                      : sb.pat_byte($urandom_range(len - 1)));
    if (kind != 0 && n >= len) begin
      repeat ($urandom_range(1, 3)) begin
        pos = $urandom_range(n - len);
        for (int k = 0; k < len; k++)
          if (!sb.wild[k]) img[pos + k] = sb.pat_byte(k);
      end
      if (kind == 1) img[pos + $urandom_range(len - 1)] ^= 8'(8'h01 << $urandom_range(7));
    end
    for (int i = 0; i < n; i++) send_byte(img[i], closed && i == n - 1);
  endtask

  initial begin : main
    int phase;
    int target;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: one-byte pattern 0x00; a match on the last byte gives both results.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();

    // Full 16-byte pattern with two wildcard positions; the address sum wraps past 2^64.
    apply_settings(make_setup('1, 64'h7766_5544_3322_1100, 64'hFFEE_DDCC_BBAA_9988,
                              64'h4002, 5'd16, 1'b0));
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    for (int k = 0; k < 16; k++)
      send_byte((k == 1 || k == 14) ? 8'h3C : sb.pat_byte(k), k == 15);
    wait_drained();

    // Length zero acts as one; every byte is a wildcard hit but first-only stops after one.
    apply_settings(make_setup(64'h0123_4567_89AB_CDEF, 64'h0, 64'h0, 64'hFFFF, 5'd0, 1'b1));
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    wait_drained();

    // Oversized length clips to 16; an image shorter than the pattern ends with the marker only.
    apply_settings(make_setup(64'h0, '1, '1, 64'h0, 5'd31, 1'b0));
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();

    // Random phases, cycling through the idle patterns of both sides.
    phase = 0;
    while (sb.bytes_in < STREAM_BYTES) begin
      case (phase % 4)
        0:       begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1:       begin send_idle_pct = 57; recv_idle_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_idle_pct = 57; end
        default: begin send_idle_pct = 26; recv_idle_pct = 26; end
      endcase
      apply_settings(random_setup());
      target = sb.bytes_in + $urandom_range(60, 140);
      while (sb.bytes_in < target) send_image();
      wait_drained();
      phase++;
    end

    $display("Streamed %0d bytes under %0d register settings and %0d idle phases.",
             sb.bytes_in, setups, phase);
    $display("Checked %0d match reports and %0d end markers.", sb.reports, sb.markers);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS wildcard_byte_pattern_scanner_top");
    end else begin
      $display("FAIL wildcard_byte_pattern_scanner_top");
    end
    $finish;
  end

endmodule
